// ----- hw/rtl/vertex_normal_average_defines.svh -----
// assertion macros used by the port-level checker file
`ifndef VERTEX_NORMAL_AVERAGE_DEFINES_SVH
`define VERTEX_NORMAL_AVERAGE_DEFINES_SVH

// same-cycle implication
`define VNA_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vertex_normal_average check failed");

// next-cycle implication
`define VNA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vertex_normal_average check failed");

`endif

// ----- hw/rtl/vna_pkg.sv -----
// shared widths, codes and control types of the vertex normal block
package vna_pkg;

    localparam int COORD_W  = 24;
    localparam int CORNER_W = 10;
    localparam int IDX_W    = 11;
    localparam int NORM_W   = 16;
    localparam int VCNT_W   = 11;
    localparam int FCNT_W   = 12;
    localparam int CFG_W    = 12;
    localparam int EXT_W    = 17;
    localparam int DIFF_W   = 25;
    localparam int MUL_W    = 31;
    localparam int PROD_W   = 62;
    localparam int ACC_W    = 64;
    localparam int MAG_W    = 30;
    localparam int SQ_W     = 62;
    localparam int ROOT_W   = 32;
    localparam int QUO_W    = 15;
    localparam int DIV_NW   = 45;
    localparam int FRAC_SH  = 14;

    localparam logic [1:0] REQ_VERTEX = 2'd0;
    localparam logic [1:0] REQ_FACE   = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam logic CFG_VCOUNT = 1'b0;
    localparam logic CFG_FCOUNT = 1'b1;

    localparam logic [1:0] CMP_X = 2'd0;
    localparam logic [1:0] CMP_Y = 2'd1;
    localparam logic [1:0] CMP_Z = 2'd2;

    localparam logic [3:0] MS_X_POS = 4'd0;
    localparam logic [3:0] MS_X_NEG = 4'd1;
    localparam logic [3:0] MS_Y_POS = 4'd2;
    localparam logic [3:0] MS_Y_NEG = 4'd3;
    localparam logic [3:0] MS_Z_POS = 4'd4;
    localparam logic [3:0] MS_Z_NEG = 4'd5;
    localparam logic [3:0] MS_SQ_X  = 4'd6;
    localparam logic [3:0] MS_SQ_Y  = 4'd7;
    localparam logic [3:0] MS_SQ_Z  = 4'd8;

    typedef struct packed {
        logic       wr_vert;
        logic       wr_face;
        logic       clr;
        logic       hit;
        logic       face_next;
        logic [1:0] vsel;
        logic       ld_p;
        logic       diff;
        logic       mul_go;
        logic [3:0] mstep;
        logic       absv;
        logic       shr;
        logic       shl;
        logic       res_zero;
        logic       res_unsh;
        logic       root_go;
        logic       div_go;
        logic [1:0] comp;
        logic       store;
    } t_cmd;

    typedef struct packed {
        logic query_ok;
        logic nf_zero;
        logic match;
        logic last_face;
        logic any;
        logic mag_zero;
        logic mag_big;
        logic mag_small;
        logic root_done;
        logic div_done;
    } t_sts;

endpackage

// ----- hw/rtl/vna_root.sv -----
// iterative integer square root, two radicand bits per cycle
module vna_root (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [vna_pkg::SQ_W-1:0]   i_value,
    output logic                       o_done,
    output logic [vna_pkg::ROOT_W-1:0] o_root
);
    localparam int RW = 64;
    localparam logic [RW-1:0] BIT_INIT = 64'h4000_0000_0000_0000;

    logic          r_run;
    logic          r_done;
    logic [4:0]    r_cnt;
    logic [RW-1:0] r_v;
    logic [RW-1:0] r_res;
    logic [RW-1:0] r_bit;
    logic [RW-1:0] n_sum;
    logic          n_ge;

    always_comb begin
        n_sum = r_res + r_bit;
        n_ge  = (r_v >= n_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == 5'd0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_v   <= RW'(i_value);
            r_res <= '0;
            r_bit <= BIT_INIT;
            r_cnt <= 5'd31;
        end else if (r_run) begin
            if (n_ge) begin
                r_v   <= r_v - n_sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt - 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[vna_pkg::ROOT_W-1:0];

endmodule

// ----- hw/rtl/vna_div.sv -----
// restoring divider, one quotient bit per cycle
module vna_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [vna_pkg::DIV_NW-1:0] i_num,
    input  logic [vna_pkg::ROOT_W-1:0] i_den,
    output logic                       o_done,
    output logic [vna_pkg::QUO_W-1:0]  o_quo
);
    localparam int RMW = vna_pkg::ROOT_W + 1;

    logic                       r_run;
    logic                       r_done;
    logic [5:0]                 r_cnt;
    logic [vna_pkg::DIV_NW-1:0] r_num;
    logic [vna_pkg::ROOT_W-1:0] r_den;
    logic [RMW-1:0]             r_rem;
    logic [vna_pkg::QUO_W-1:0]  r_quo;
    logic [RMW-1:0]             n_rem;
    logic                       n_ge;

    always_comb begin
        n_rem = {r_rem[vna_pkg::ROOT_W-1:0], r_num[vna_pkg::DIV_NW-1]};
        n_ge  = (n_rem >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == 6'd0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= 6'(vna_pkg::DIV_NW - 1);
        end else if (r_run) begin
            r_rem <= n_ge ? (n_rem - {1'b0, r_den}) : n_rem;
            r_quo <= {r_quo[vna_pkg::QUO_W-2:0], n_ge};
            r_num <= r_num << 1;
            r_cnt <= r_cnt - 6'd1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- hw/rtl/vna_dp.sv -----
// datapath: stores, face walk, cross products, normalize, root and divide
module vna_dp #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_FACES    = 2048
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [vna_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [vna_pkg::IDX_W-1:0]          i_item_index,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_z,
    input  logic [vna_pkg::CORNER_W-1:0]       i_corner_a,
    input  logic [vna_pkg::CORNER_W-1:0]       i_corner_b,
    input  logic [vna_pkg::CORNER_W-1:0]       i_corner_c,
    input  vna_pkg::t_cmd                      i_cmd,
    output vna_pkg::t_sts                      o_sts,
    output logic signed [vna_pkg::NORM_W-1:0]  o_normal_x,
    output logic signed [vna_pkg::NORM_W-1:0]  o_normal_y,
    output logic signed [vna_pkg::NORM_W-1:0]  o_normal_z,
    output logic                               o_unshared
);
    localparam int VA = $clog2(MAX_VERTICES);
    localparam int FA = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int EW = vna_pkg::EXT_W;
    localparam int CW = vna_pkg::COORD_W;
    localparam int NW = vna_pkg::CORNER_W;
    localparam logic [EW-1:0] MAXV = EW'(MAX_VERTICES);
    localparam logic [EW-1:0] MAXF = EW'(MAX_FACES);

    logic [3*CW-1:0] r_vmem [MAX_VERTICES];
    logic [3*NW-1:0] r_fmem [MAX_FACES];

    logic [vna_pkg::VCNT_W-1:0] r_vcount;
    logic [vna_pkg::FCNT_W-1:0] r_fcount;

    logic [FA-1:0]   r_fidx;
    logic [3*NW-1:0] r_fdata;
    logic [3*CW-1:0] r_vdata;
    logic            r_vzero;
    logic [EW-1:0]   r_vid;
    logic            r_any;

    logic signed [CW-1:0]              r_p [3][3];
    logic signed [vna_pkg::DIFF_W-1:0] r_a [3];
    logic signed [vna_pkg::DIFF_W-1:0] r_c [3];

    logic signed [vna_pkg::PROD_W-1:0] r_prod;
    logic [3:0]                        r_pstep;
    logic                              r_pvld;
    logic signed [vna_pkg::ACC_W-1:0]  r_acc [3];
    logic [vna_pkg::ACC_W-1:0]         r_mag [3];
    logic                              r_neg [3];
    logic [vna_pkg::SQ_W-1:0]          r_sq;

    logic signed [vna_pkg::NORM_W-1:0] r_norm [3];
    logic                              r_unsh;

    logic [EW-1:0]                     n_idx_ext;
    logic [EW-1:0]                     n_nf;
    logic [EW-1:0]                     n_cor [3];
    logic [EW-1:0]                     n_vext;
    logic signed [vna_pkg::MUL_W-1:0]  n_opa;
    logic signed [vna_pkg::MUL_W-1:0]  n_opb;
    logic signed [vna_pkg::ACC_W-1:0]  n_pext;
    logic [vna_pkg::ACC_W-1:0]         n_mor;
    logic [vna_pkg::ROOT_W-1:0]        n_root;
    logic                              n_root_done;
    logic [vna_pkg::DIV_NW-1:0]        n_num;
    logic [vna_pkg::QUO_W-1:0]         n_quo;
    logic                              n_div_done;
    logic [vna_pkg::NORM_W-1:0]        n_qext;

    always_comb begin
        n_idx_ext = EW'(i_item_index);
        n_nf      = (EW'(r_fcount) > MAXF) ? MAXF : EW'(r_fcount);
        n_cor[0]  = EW'(r_fdata[3*NW-1:2*NW]);
        n_cor[1]  = EW'(r_fdata[2*NW-1:NW]);
        n_cor[2]  = EW'(r_fdata[NW-1:0]);
        case (i_cmd.vsel)
            vna_pkg::CMP_Y: n_vext = n_cor[1];
            vna_pkg::CMP_Z: n_vext = n_cor[2];
            default:        n_vext = n_cor[0];
        endcase
        n_mor  = r_mag[0] | r_mag[1] | r_mag[2];
        n_pext = {{(vna_pkg::ACC_W - vna_pkg::PROD_W){r_prod[vna_pkg::PROD_W-1]}}, r_prod};
        n_num  = (vna_pkg::DIV_NW'(r_mag[i_cmd.comp][vna_pkg::MAG_W-1:0]) << vna_pkg::FRAC_SH)
                 + vna_pkg::DIV_NW'(n_root >> 1);
        n_qext = vna_pkg::NORM_W'(n_quo);
    end

    // multiplier operand select
    always_comb begin
        case (i_cmd.mstep)
            vna_pkg::MS_X_POS: begin n_opa = vna_pkg::MUL_W'(r_a[1]); n_opb = vna_pkg::MUL_W'(r_c[2]); end
            vna_pkg::MS_X_NEG: begin n_opa = vna_pkg::MUL_W'(r_a[2]); n_opb = vna_pkg::MUL_W'(r_c[1]); end
            vna_pkg::MS_Y_POS: begin n_opa = vna_pkg::MUL_W'(r_a[2]); n_opb = vna_pkg::MUL_W'(r_c[0]); end
            vna_pkg::MS_Y_NEG: begin n_opa = vna_pkg::MUL_W'(r_a[0]); n_opb = vna_pkg::MUL_W'(r_c[2]); end
            vna_pkg::MS_Z_POS: begin n_opa = vna_pkg::MUL_W'(r_a[0]); n_opb = vna_pkg::MUL_W'(r_c[1]); end
            vna_pkg::MS_Z_NEG: begin n_opa = vna_pkg::MUL_W'(r_a[1]); n_opb = vna_pkg::MUL_W'(r_c[0]); end
            vna_pkg::MS_SQ_X: begin
                n_opa = {1'b0, r_mag[0][vna_pkg::MAG_W-1:0]};
                n_opb = {1'b0, r_mag[0][vna_pkg::MAG_W-1:0]};
            end
            vna_pkg::MS_SQ_Y: begin
                n_opa = {1'b0, r_mag[1][vna_pkg::MAG_W-1:0]};
                n_opb = {1'b0, r_mag[1][vna_pkg::MAG_W-1:0]};
            end
            vna_pkg::MS_SQ_Z: begin
                n_opa = {1'b0, r_mag[2][vna_pkg::MAG_W-1:0]};
                n_opb = {1'b0, r_mag[2][vna_pkg::MAG_W-1:0]};
            end
            default: begin n_opa = '0; n_opb = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
            r_fcount <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vna_pkg::CFG_VCOUNT: r_vcount <= i_cfg_data[vna_pkg::VCNT_W-1:0];
                vna_pkg::CFG_FCOUNT: r_fcount <= i_cfg_data[vna_pkg::FCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_vert && n_idx_ext < MAXV) begin
            r_vmem[n_idx_ext[VA-1:0]] <= {i_coord_x, i_coord_y, i_coord_z};
        end
        r_vdata <= r_vmem[n_vext[VA-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_face && n_idx_ext < MAXF) begin
            r_fmem[n_idx_ext[FA-1:0]] <= {i_corner_a, i_corner_b, i_corner_c};
        end
        r_fdata <= r_fmem[r_fidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
            r_any  <= 1'b0;
        end else begin
            r_pvld <= i_cmd.mul_go;
            if (i_cmd.clr) begin
                r_any <= 1'b0;
            end else if (i_cmd.hit) begin
                r_any <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vzero <= (n_vext >= MAXV);
        if (i_cmd.clr) begin
            r_vid  <= n_idx_ext;
            r_fidx <= '0;
        end else if (i_cmd.face_next) begin
            r_fidx <= r_fidx + FA'(1);
        end
        if (i_cmd.ld_p) begin
            r_p[i_cmd.comp][0] <= r_vzero ? '0 : r_vdata[3*CW-1:2*CW];
            r_p[i_cmd.comp][1] <= r_vzero ? '0 : r_vdata[2*CW-1:CW];
            r_p[i_cmd.comp][2] <= r_vzero ? '0 : r_vdata[CW-1:0];
        end
        if (i_cmd.diff) begin
            for (int k = 0; k < 3; k++) begin
                r_a[k] <= {r_p[0][k][CW-1], r_p[0][k]} - {r_p[2][k][CW-1], r_p[2][k]};
                r_c[k] <= {r_p[2][k][CW-1], r_p[2][k]} - {r_p[1][k][CW-1], r_p[1][k]};
            end
        end
        r_prod  <= n_opa * n_opb;
        r_pstep <= i_cmd.mstep;
    end

    // accumulate, normalize, square sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= '0;
            end
        end else if (r_pvld) begin
            case (r_pstep)
                vna_pkg::MS_X_POS: r_acc[0] <= r_acc[0] + n_pext;
                vna_pkg::MS_X_NEG: r_acc[0] <= r_acc[0] - n_pext;
                vna_pkg::MS_Y_POS: r_acc[1] <= r_acc[1] + n_pext;
                vna_pkg::MS_Y_NEG: r_acc[1] <= r_acc[1] - n_pext;
                vna_pkg::MS_Z_POS: r_acc[2] <= r_acc[2] + n_pext;
                vna_pkg::MS_Z_NEG: r_acc[2] <= r_acc[2] - n_pext;
                default: ;
            endcase
        end
        if (i_cmd.absv) begin
            r_sq <= '0;
        end else if (r_pvld && (r_pstep == vna_pkg::MS_SQ_X || r_pstep == vna_pkg::MS_SQ_Y
                                || r_pstep == vna_pkg::MS_SQ_Z)) begin
            r_sq <= r_sq + r_prod[vna_pkg::SQ_W-1:0];
        end
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.absv) begin
                r_neg[k] <= r_acc[k][vna_pkg::ACC_W-1];
                r_mag[k] <= r_acc[k][vna_pkg::ACC_W-1] ? -r_acc[k] : r_acc[k];
            end else if (i_cmd.shr) begin
                r_mag[k] <= r_mag[k] >> 1;
            end else if (i_cmd.shl) begin
                r_mag[k] <= r_mag[k] << 1;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_zero) begin
            for (int k = 0; k < 3; k++) begin
                r_norm[k] <= '0;
            end
            r_unsh <= i_cmd.res_unsh;
        end else if (i_cmd.absv) begin
            r_unsh <= 1'b0;
        end
        if (i_cmd.store) begin
            r_norm[i_cmd.comp] <= r_neg[i_cmd.comp] ? n_qext : -n_qext;
        end
    end

    vna_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.root_go),
        .i_value (r_sq),
        .o_done  (n_root_done),
        .o_root  (n_root)
    );

    vna_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (n_num),
        .i_den   (n_root),
        .o_done  (n_div_done),
        .o_quo   (n_quo)
    );

    always_comb begin
        o_sts.query_ok  = (n_idx_ext < EW'(r_vcount)) && (n_idx_ext < MAXV);
        o_sts.nf_zero   = (n_nf == '0);
        o_sts.match     = (n_cor[0] == r_vid) || (n_cor[1] == r_vid) || (n_cor[2] == r_vid);
        o_sts.last_face = (EW'(r_fidx) == n_nf - EW'(1));
        o_sts.any       = r_any;
        o_sts.mag_zero  = (n_mor == '0);
        o_sts.mag_big   = |n_mor[vna_pkg::ACC_W-1:vna_pkg::MAG_W];
        o_sts.mag_small = !n_mor[vna_pkg::MAG_W-1];
        o_sts.root_done = n_root_done;
        o_sts.div_done  = n_div_done;
    end

    assign o_normal_x = r_norm[0];
    assign o_normal_y = r_norm[1];
    assign o_normal_z = r_norm[2];
    assign o_unshared = r_unsh;

endmodule

// ----- hw/rtl/vna_ctrl.sv -----
// controller: sequences loads, the face walk and the normalize steps
module vna_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic [1:0]    i_req_type,
    input  vna_pkg::t_sts i_sts,
    output vna_pkg::t_cmd o_cmd,
    output logic          busy,
    output logic          o_valid
);
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_FADDR  = 5'd1;
    localparam logic [4:0] ST_FCHK   = 5'd2;
    localparam logic [4:0] ST_V0     = 5'd3;
    localparam logic [4:0] ST_V1     = 5'd4;
    localparam logic [4:0] ST_V2     = 5'd5;
    localparam logic [4:0] ST_V3     = 5'd6;
    localparam logic [4:0] ST_DIFF   = 5'd7;
    localparam logic [4:0] ST_MUL    = 5'd8;
    localparam logic [4:0] ST_MDRAIN = 5'd9;
    localparam logic [4:0] ST_POST   = 5'd10;
    localparam logic [4:0] ST_NORM   = 5'd11;
    localparam logic [4:0] ST_SQ     = 5'd12;
    localparam logic [4:0] ST_SDRAIN = 5'd13;
    localparam logic [4:0] ST_RGO    = 5'd14;
    localparam logic [4:0] ST_RWAIT  = 5'd15;
    localparam logic [4:0] ST_DGO    = 5'd16;
    localparam logic [4:0] ST_DWAIT  = 5'd17;
    localparam logic [4:0] ST_OUT    = 5'd18;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic [3:0] r_mstep;
    logic [3:0] n_mstep;
    logic [1:0] r_comp;
    logic [1:0] n_comp;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_mstep = r_mstep;
        n_comp  = r_comp;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_req_type)
                        vna_pkg::REQ_VERTEX: o_cmd.wr_vert = 1'b1;
                        vna_pkg::REQ_FACE:   o_cmd.wr_face = 1'b1;
                        vna_pkg::REQ_QUERY: begin
                            if (!i_sts.query_ok) begin
                                o_cmd.res_zero = 1'b1;
                                o_cmd.res_unsh = 1'b1;
                                n_state        = ST_OUT;
                            end else begin
                                o_cmd.clr = 1'b1;
                                n_state   = i_sts.nf_zero ? ST_POST : ST_FADDR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FADDR: n_state = ST_FCHK;
            ST_FCHK: begin
                if (i_sts.match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = ST_V0;
                end else begin
                    o_cmd.face_next = 1'b1;
                    n_state         = i_sts.last_face ? ST_POST : ST_FADDR;
                end
            end
            ST_V0: begin
                o_cmd.vsel = vna_pkg::CMP_X;
                n_state    = ST_V1;
            end
            ST_V1: begin
                o_cmd.vsel = vna_pkg::CMP_Y;
                o_cmd.ld_p = 1'b1;
                o_cmd.comp = vna_pkg::CMP_X;
                n_state    = ST_V2;
            end
            ST_V2: begin
                o_cmd.vsel = vna_pkg::CMP_Z;
                o_cmd.ld_p = 1'b1;
                o_cmd.comp = vna_pkg::CMP_Y;
                n_state    = ST_V3;
            end
            ST_V3: begin
                o_cmd.ld_p = 1'b1;
                o_cmd.comp = vna_pkg::CMP_Z;
                n_state    = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_mstep    = vna_pkg::MS_X_POS;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.mstep  = r_mstep;
                n_mstep      = r_mstep + 4'd1;
                if (r_mstep == vna_pkg::MS_Z_NEG) begin
                    n_state = ST_MDRAIN;
                end
            end
            ST_MDRAIN: begin
                o_cmd.face_next = 1'b1;
                n_state         = i_sts.last_face ? ST_POST : ST_FADDR;
            end
            ST_POST: begin
                if (!i_sts.any) begin
                    o_cmd.res_zero = 1'b1;
                    o_cmd.res_unsh = 1'b1;
                    n_state        = ST_OUT;
                end else begin
                    o_cmd.absv = 1'b1;
                    n_state    = ST_NORM;
                end
            end
            ST_NORM: begin
                if (i_sts.mag_zero) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = ST_OUT;
                end else if (i_sts.mag_big) begin
                    o_cmd.shr = 1'b1;
                end else if (i_sts.mag_small) begin
                    o_cmd.shl = 1'b1;
                end else begin
                    n_mstep = vna_pkg::MS_SQ_X;
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.mstep  = r_mstep;
                n_mstep      = r_mstep + 4'd1;
                if (r_mstep == vna_pkg::MS_SQ_Z) begin
                    n_state = ST_SDRAIN;
                end
            end
            ST_SDRAIN: n_state = ST_RGO;
            ST_RGO: begin
                o_cmd.root_go = 1'b1;
                n_state       = ST_RWAIT;
            end
            ST_RWAIT: begin
                if (i_sts.root_done) begin
                    n_comp  = vna_pkg::CMP_X;
                    n_state = ST_DGO;
                end
            end
            ST_DGO: begin
                o_cmd.div_go = 1'b1;
                o_cmd.comp   = r_comp;
                n_state      = ST_DWAIT;
            end
            ST_DWAIT: begin
                o_cmd.comp = r_comp;
                if (i_sts.div_done) begin
                    o_cmd.store = 1'b1;
                    if (r_comp == vna_pkg::CMP_Z) begin
                        n_state = ST_OUT;
                    end else begin
                        n_comp  = r_comp + 2'd1;
                        n_state = ST_DGO;
                    end
                end
            end
            ST_OUT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mstep <= '0;
            r_comp  <= '0;
        end else begin
            r_state <= n_state;
            r_mstep <= n_mstep;
            r_comp  <= n_comp;
        end
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);

endmodule

// ----- hw/rtl/vertex_normal_average.sv -----
// top level: smooth vertex normal from face normal sums, Q1.14 result
// load beats are taken while idle and leave busy low; a query holds busy from
// accept to the result beat while it walks the faces and normalizes the sums
// by shifts; its steps run through the face walk, the shared 31x31
// multiplier, the 32-step root and three 45-step divides; one query at a time
// synchronous active-low reset clears counts and control; stores keep contents
module vertex_normal_average #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_FACES    = 2048
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [vna_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               start,
    input  logic [1:0]                         i_req_type,
    input  logic [vna_pkg::IDX_W-1:0]          i_item_index,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_z,
    input  logic [vna_pkg::CORNER_W-1:0]       i_corner_a,
    input  logic [vna_pkg::CORNER_W-1:0]       i_corner_b,
    input  logic [vna_pkg::CORNER_W-1:0]       i_corner_c,
    output logic                               busy,
    output logic                               o_valid,
    output logic signed [vna_pkg::NORM_W-1:0]  o_normal_x,
    output logic signed [vna_pkg::NORM_W-1:0]  o_normal_y,
    output logic signed [vna_pkg::NORM_W-1:0]  o_normal_z,
    output logic                               o_unshared
);
    vna_pkg::t_cmd cmd;
    vna_pkg::t_sts sts;

    vna_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .busy       (busy),
        .o_valid    (o_valid)
    );

    vna_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_FACES    (MAX_FACES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item_index (i_item_index),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_z    (i_coord_z),
        .i_corner_a   (i_corner_a),
        .i_corner_b   (i_corner_b),
        .i_corner_c   (i_corner_c),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_normal_x   (o_normal_x),
        .o_normal_y   (o_normal_y),
        .o_normal_z   (o_normal_z),
        .o_unshared   (o_unshared)
    );

endmodule

// ----- hw/rtl/vna_checker.sv -----
// port-level checks of the vertex normal block and their bind
`include "vertex_normal_average_defines.svh"

module vna_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic [1:0]                         i_req_type,
    input logic                               busy,
    input logic                               o_valid,
    input logic signed [vna_pkg::NORM_W-1:0]  o_normal_x,
    input logic signed [vna_pkg::NORM_W-1:0]  o_normal_y,
    input logic signed [vna_pkg::NORM_W-1:0]  o_normal_z,
    input logic                               o_unshared
);
    `VNA_ASSERT_NOW(a_valid_in_busy, o_valid, busy)
    `VNA_ASSERT_NEXT(a_idle_after_beat, o_valid, !busy)
    `VNA_ASSERT_NEXT(a_load_no_stall, start && !busy && i_req_type != vna_pkg::REQ_QUERY, !busy)
    `VNA_ASSERT_NEXT(a_query_busy, start && !busy && i_req_type == vna_pkg::REQ_QUERY, busy)
    `VNA_ASSERT_NOW(a_unshared_zero, o_valid && o_unshared, o_normal_x == 0 && o_normal_y == 0 && o_normal_z == 0)

endmodule

bind vertex_normal_average vna_checker u_vna_checker (.*);

// ----- tb/sv/vna_normal_checker.sv -----
// checker for vertex_normal_average: mirrors the stores, predicts each query and compares results
module vna_normal_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [vna_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_start,
    input  logic                               i_busy,
    input  logic [1:0]                         i_req_type,
    input  logic [vna_pkg::IDX_W-1:0]          i_item_index,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_z,
    input  logic [vna_pkg::CORNER_W-1:0]       i_corner_a,
    input  logic [vna_pkg::CORNER_W-1:0]       i_corner_b,
    input  logic [vna_pkg::CORNER_W-1:0]       i_corner_c,
    input  logic                               i_valid,
    input  logic signed [vna_pkg::NORM_W-1:0]  i_normal_x,
    input  logic signed [vna_pkg::NORM_W-1:0]  i_normal_y,
    input  logic signed [vna_pkg::NORM_W-1:0]  i_normal_z,
    input  logic                               i_unshared,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_VERTS = 1024;
    localparam int NUM_FACES = 2048;
    localparam int DUE_DEPTH = 16;

    typedef struct packed {
        logic signed [vna_pkg::NORM_W-1:0] x;
        logic signed [vna_pkg::NORM_W-1:0] y;
        logic signed [vna_pkg::NORM_W-1:0] z;
        logic                              unsh;
    } t_normal;

    logic signed [vna_pkg::COORD_W-1:0]  vert_pos [NUM_VERTS][3];
    logic        [vna_pkg::CORNER_W-1:0] face_crn [NUM_FACES][3];
    logic        [vna_pkg::VCNT_W-1:0]   vert_cnt;
    logic        [vna_pkg::FCNT_W-1:0]   face_cnt;
    t_normal                             due_q [DUE_DEPTH];
    int                                  due_wr = 0;
    int                                  due_rd = 0;

    function automatic t_normal smooth_normal(int unsigned vid);
        logic signed [127:0] acc [3];
        logic        [127:0] m [3];
        logic        [63:0]  mag [3];
        logic        [63:0]  sq, root, bitv, rem, n;
        bit                  neg [3];
        bit                  hit;
        int                  nf, maxb, b;
        longint              p0 [3], p1 [3], p2 [3], a [3], c [3];
        t_normal             r;
        r = '0;
        r.unsh = 1'b1;
        hit = 0;
        if (vid >= vert_cnt || vid >= NUM_VERTS) return r;
        nf = (face_cnt > NUM_FACES) ? NUM_FACES : face_cnt;
        for (int k = 0; k < 3; k++) acc[k] = '0;
        for (int j = 0; j < nf; j++) begin
            if (face_crn[j][0] != vid && face_crn[j][1] != vid && face_crn[j][2] != vid)
                continue;
            hit = 1;
            for (int k = 0; k < 3; k++) begin
                p0[k] = vert_pos[face_crn[j][0]][k];
                p1[k] = vert_pos[face_crn[j][1]][k];
                p2[k] = vert_pos[face_crn[j][2]][k];
                a[k] = p0[k] - p2[k];
                c[k] = p2[k] - p1[k];
            end
            acc[0] = acc[0] + (a[1] * c[2] - a[2] * c[1]);
            acc[1] = acc[1] + (a[2] * c[0] - a[0] * c[2]);
            acc[2] = acc[2] + (a[0] * c[1] - a[1] * c[0]);
        end
        if (!hit) return r;
        r.unsh = 1'b0;
        maxb = 0;
        for (int k = 0; k < 3; k++) begin
            neg[k] = acc[k][127];
            m[k] = neg[k] ? -acc[k] : acc[k];
            for (b = 128; b > 0 && !m[k][b-1]; b--) ;
            if (b > maxb) maxb = b;
        end
        if (maxb == 0) return r;
        sq = '0;
        for (int k = 0; k < 3; k++) begin
            if (maxb > vna_pkg::MAG_W) m[k] = m[k] >> (maxb - vna_pkg::MAG_W);
            else m[k] = m[k] << (vna_pkg::MAG_W - maxb);
            mag[k] = m[k][63:0];
            sq = sq + mag[k] * mag[k];
        end
        // bitwise integer square root
        root = '0;
        rem = sq;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        for (int k = 0; k < 3; k++) begin
            n = (mag[k] * 64'd16384 + root / 2) / root;
            if (!neg[k]) n = -n;
            case (k)
                0: r.x = n[vna_pkg::NORM_W-1:0];
                1: r.y = n[vna_pkg::NORM_W-1:0];
                default: r.z = n[vna_pkg::NORM_W-1:0];
            endcase
        end
        return r;
    endfunction

    assign o_pending = due_wr - due_rd;

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_normal got, want;
        if (!i_rst_n) begin
            vert_cnt = '0;
            face_cnt = '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == vna_pkg::CFG_VCOUNT) vert_cnt = i_cfg_data[vna_pkg::VCNT_W-1:0];
                else face_cnt = i_cfg_data[vna_pkg::FCNT_W-1:0];
            end
            if (i_valid) begin
                got = '{i_normal_x, i_normal_y, i_normal_z, i_unshared};
                if (due_wr == due_rd) begin
                    $error("result beat with no query outstanding");
                    o_fail_count++;
                end else begin
                    want = due_q[due_rd % DUE_DEPTH];
                    due_rd++;
                    if (got.x !== want.x) begin
                        $error("normal_x expected %0d actual %0d", want.x, got.x);
                        o_fail_count++;
                    end
                    if (got.y !== want.y) begin
                        $error("normal_y expected %0d actual %0d", want.y, got.y);
                        o_fail_count++;
                    end
                    if (got.z !== want.z) begin
                        $error("normal_z expected %0d actual %0d", want.z, got.z);
                        o_fail_count++;
                    end
                    if (got.unsh !== want.unsh) begin
                        $error("unshared expected %0d actual %0d", want.unsh, got.unsh);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                case (i_req_type)
                    vna_pkg::REQ_VERTEX: if (i_item_index < NUM_VERTS) begin
                        vert_pos[i_item_index][0] = i_coord_x;
                        vert_pos[i_item_index][1] = i_coord_y;
                        vert_pos[i_item_index][2] = i_coord_z;
                    end
                    vna_pkg::REQ_FACE: if (i_item_index < NUM_FACES) begin
                        face_crn[i_item_index][0] = i_corner_a;
                        face_crn[i_item_index][1] = i_corner_b;
                        face_crn[i_item_index][2] = i_corner_c;
                    end
                    vna_pkg::REQ_QUERY: begin
                        due_q[due_wr % DUE_DEPTH] = smooth_normal(i_item_index);
                        due_wr++;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench top for vertex_normal_average: mesh loads and normal queries, verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 300000;
    localparam int FILL_N     = 32;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic                               i_cfg_idx = 1'b0;
    logic [vna_pkg::CFG_W-1:0]          i_cfg_data = '0;
    logic                               start = 1'b0;
    logic [1:0]                         i_req_type = vna_pkg::REQ_VERTEX;
    logic [vna_pkg::IDX_W-1:0]          i_item_index = '0;
    logic signed [vna_pkg::COORD_W-1:0] i_coord_x = '0;
    logic signed [vna_pkg::COORD_W-1:0] i_coord_y = '0;
    logic signed [vna_pkg::COORD_W-1:0] i_coord_z = '0;
    logic [vna_pkg::CORNER_W-1:0]       i_corner_a = '0;
    logic [vna_pkg::CORNER_W-1:0]       i_corner_b = '0;
    logic [vna_pkg::CORNER_W-1:0]       i_corner_c = '0;
    logic                               busy;
    logic                               o_valid;
    logic signed [vna_pkg::NORM_W-1:0]  o_normal_x;
    logic signed [vna_pkg::NORM_W-1:0]  o_normal_y;
    logic signed [vna_pkg::NORM_W-1:0]  o_normal_z;
    logic                               o_unshared;
    int                                 fail_count;
    int                                 pending;
    int                                 idle_cycles = 0;
    int                                 vc, fc;
    bit                                 no_gaps;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    vertex_normal_average dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .start,
        .i_req_type, .i_item_index, .i_coord_x, .i_coord_y, .i_coord_z,
        .i_corner_a, .i_corner_b, .i_corner_c, .busy, .o_valid,
        .o_normal_x, .o_normal_y, .o_normal_z, .o_unshared
    );

    vna_normal_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .i_start(start),
        .i_busy(busy), .i_req_type, .i_item_index, .i_coord_x, .i_coord_y,
        .i_coord_z, .i_corner_a, .i_corner_b, .i_corner_c, .i_valid(o_valid),
        .i_normal_x(o_normal_x), .i_normal_y(o_normal_y), .i_normal_z(o_normal_z),
        .i_unshared(o_unshared), .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(logic [1:0] rt, logic [vna_pkg::IDX_W-1:0] idx,
                             logic signed [vna_pkg::COORD_W-1:0] x,
                             logic signed [vna_pkg::COORD_W-1:0] y,
                             logic signed [vna_pkg::COORD_W-1:0] z,
                             logic [vna_pkg::CORNER_W-1:0] ca,
                             logic [vna_pkg::CORNER_W-1:0] cb,
                             logic [vna_pkg::CORNER_W-1:0] cc);
        start        <= 1'b1;
        i_req_type   <= rt;
        i_item_index <= idx;
        i_coord_x    <= x;
        i_coord_y    <= y;
        i_coord_z    <= z;
        i_corner_a   <= ca;
        i_corner_b   <= cb;
        i_corner_c   <= cc;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic put_vertex(int idx, int x, int y, int z);
        send_beat(vna_pkg::REQ_VERTEX, vna_pkg::IDX_W'(idx), vna_pkg::COORD_W'(x),
                  vna_pkg::COORD_W'(y), vna_pkg::COORD_W'(z), vna_pkg::CORNER_W'($urandom),
                  vna_pkg::CORNER_W'($urandom), vna_pkg::CORNER_W'($urandom));
    endtask

    task automatic put_face(int idx, int ca, int cb, int cc);
        send_beat(vna_pkg::REQ_FACE, vna_pkg::IDX_W'(idx), vna_pkg::COORD_W'($urandom),
                  vna_pkg::COORD_W'($urandom), vna_pkg::COORD_W'($urandom),
                  vna_pkg::CORNER_W'(ca), vna_pkg::CORNER_W'(cb), vna_pkg::CORNER_W'(cc));
    endtask

    task automatic ask_normal(int idx);
        send_beat(vna_pkg::REQ_QUERY, vna_pkg::IDX_W'(idx), vna_pkg::COORD_W'($urandom),
                  vna_pkg::COORD_W'($urandom), vna_pkg::COORD_W'($urandom),
                  vna_pkg::CORNER_W'($urandom), vna_pkg::CORNER_W'($urandom),
                  vna_pkg::CORNER_W'($urandom));
    endtask

    task automatic send_junk();
        send_beat(REQ_UNUSED, vna_pkg::IDX_W'($urandom), vna_pkg::COORD_W'($urandom),
                  vna_pkg::COORD_W'($urandom), vna_pkg::COORD_W'($urandom),
                  vna_pkg::CORNER_W'($urandom), vna_pkg::CORNER_W'($urandom),
                  vna_pkg::CORNER_W'($urandom));
    endtask

    task automatic idle_gap();
        int r, n;
        r = $urandom_range(0, 99);
        n = no_gaps ? 0 : (r < 55) ? 0
            : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // wait for all results and a quiet block, then write one register
    task automatic cfg_write(logic idx, int value);
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= vna_pkg::CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic int rand_coord();
        if ($urandom_range(0, 3) == 0) return $signed($urandom_range(0, 24'hFFFFFF) - 24'h800000);
        return $urandom_range(0, 80000) - 40000;
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the low slots so no face walk reads an unwritten entry
        no_gaps = 1;
        cfg_write(vna_pkg::CFG_VCOUNT, 1024);
        cfg_write(vna_pkg::CFG_FCOUNT, 0);
        for (int i = 0; i < FILL_N; i++) put_vertex(i, rand_coord(), rand_coord(), rand_coord());
        put_vertex(1023, rand_coord(), rand_coord(), rand_coord());
        for (int i = 0; i < FILL_N; i++)
            put_face(i, $urandom_range(0, FILL_N - 1), $urandom_range(0, FILL_N - 1),
                     $urandom_range(0, FILL_N - 1));

        // directed: extremes, cancelling faces, unused vertex, out of range
        cfg_write(vna_pkg::CFG_VCOUNT, 8);
        cfg_write(vna_pkg::CFG_FCOUNT, 4);
        put_vertex(0, 0, 0, 0);
        put_vertex(1, 4096, 0, 0);
        put_vertex(2, 0, 4096, 0);
        put_vertex(3, 8388607, -8388608, 8388607);
        put_face(0, 0, 1, 2);
        put_face(1, 0, 2, 1);
        put_face(2, 3, 1, 2);
        put_face(3, 1023, 3, 0);
        put_vertex(2000, 5, 5, 5);
        send_beat(REQ_UNUSED, vna_pkg::IDX_W'(2047), vna_pkg::COORD_W'(-8388608),
                  vna_pkg::COORD_W'(8388607), vna_pkg::COORD_W'(-1),
                  vna_pkg::CORNER_W'(1023), vna_pkg::CORNER_W'(1023), vna_pkg::CORNER_W'(1023));
        for (int i = 0; i < 5; i++) ask_normal(i);
        ask_normal(8);
        ask_normal(2047);
        cfg_write(vna_pkg::CFG_FCOUNT, 2);
        ask_normal(0);
        ask_normal(3);
        cfg_write(vna_pkg::CFG_VCOUNT, 2047);
        cfg_write(vna_pkg::CFG_FCOUNT, FILL_N);
        ask_normal(3);
        ask_normal(1500);
        cfg_write(vna_pkg::CFG_VCOUNT, 0);
        ask_normal(0);

        // random phases on small meshes
        for (int ph = 0; ph < 8; ph++) begin
            vc = (ph == 2) ? 1024 : (ph == 5) ? 0 : $urandom_range(4, 16);
            fc = (ph == 6) ? 0 : $urandom_range(1, 24);
            no_gaps = (ph == 3);
            cfg_write(vna_pkg::CFG_VCOUNT, vc);
            cfg_write(vna_pkg::CFG_FCOUNT, fc);
            for (int i = 0; i < 25; i++) begin
                int r, mv;
                r = $urandom_range(0, 99);
                mv = (vc > 16 || vc == 0) ? 16 : vc;
                if (r < 30)
                    put_vertex(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                               : $urandom_range(0, mv - 1), rand_coord(), rand_coord(),
                               rand_coord());
                else if (r < 55)
                    put_face(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                             : $urandom_range(0, fc + 2),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(0, FILL_N - 1)
                             : $urandom_range(0, mv - 1),
                             $urandom_range(0, mv - 1), $urandom_range(0, mv - 1));
                else if (r < 95)
                    ask_normal(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                               : $urandom_range(0, mv - 1));
                else
                    send_junk();
                idle_gap();
            end
        end

        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
